// ----- hdl/r2fft_pkg.sv -----
// Shared constants and codes for the in-place radix-2 FFT block.
// No dependencies; used by radix2_dit_fft_inplace.
package r2fft_pkg;

    // sizes of the store and the fixed-point formats
    localparam int MAX_LOG2     = 10;
    localparam int SAMPLE_WIDTH = 16;
    localparam int TW_WIDTH     = 32;
    localparam int INDEX_W      = 10;
    localparam int ADDR_W       = MAX_LOG2;
    localparam int CNT_W        = MAX_LOG2 + 1;
    localparam int STAGE_W      = $clog2(MAX_LOG2 + 1);
    localparam int TW_AW        = $clog2(MAX_LOG2);
    localparam int LOG2_W       = 4;
    localparam int PROD_W       = 2 * TW_WIDTH;
    localparam int ACC_W        = PROD_W + 2;
    localparam int BF_W         = ACC_W + 1;
    localparam int Q_FRAC       = 30;
    localparam int MUL_STEPS    = 4;
    localparam int MUL_CNT_W    = 3;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG2_POINTS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_SCALING   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_MODE = 2'd2;
    localparam logic [LOG2_W-1:0]      LOG2_RESET       = 4'd10;

    // 1.0 in Q1.30
    localparam logic signed [TW_WIDTH-1:0] TW_ONE = TW_WIDTH'(1) << Q_FRAC;

    // command codes of the input item
    typedef enum logic [1:0] {
        KIND_LOAD_TW     = 2'd0,
        KIND_LOAD_SAMPLE = 2'd1,
        KIND_RUN         = 2'd2,
        KIND_READ        = 2'd3
    } kind_t;

endpackage

// ----- hdl/radix2_dit_fft_inplace.sv -----
// In-place radix-2 decimation-in-time FFT with sample store and twiddle steps.
// Depends on r2fft_pkg (constants, command codes).
//
// Usage:
//  - Input channel (in_valid / in_stall) carries commands selected by kind:
//    load twiddle step (index = stage), load sample (index = address),
//    run transform, read bin (index = address). Samples go in bit-reversed.
//  - Output channel (out_valid / out_stall) returns one transfer per read:
//    bin_re, bin_im and the sticky saturated flag of the last run.
//  - Config channel (cfg_valid / cfg_ready, always ready) writes
//    log2_points, no_scaling, inverse_mode; write only while idle.
//  - A read returns its bin through the registered memory read and the
//    output register; the input stalls while a read is in flight, so a
//    new read is taken only once the previous bin is in the output register.
//  - A run holds the input until its last stage ends. A butterfly steps
//    S_RD_D, S_RD_I, S_MUL, S_WR_D, S_WR_I; a twiddle advance S_MUL, S_TW_FIN;
//    both are paced by the one write and one read port of the sample memory
//    and one shared 32x32 multiplier used four times per complex product.
//  - Reset clears the registers to log2_points 10, scaling on, flag clear;
//    the sample and twiddle stores keep no reset value.
//  - A stalled output holds its bin and stalls the input channel.
module radix2_dit_fft_inplace (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [1:0]                                kind,
    input  logic [r2fft_pkg::INDEX_W-1:0]             index,
    input  logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] sample_im,
    input  logic signed [r2fft_pkg::TW_WIDTH-1:0]     twiddle_re,
    input  logic signed [r2fft_pkg::TW_WIDTH-1:0]     twiddle_im,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] bin_re,
    output logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] bin_im,
    output logic                                      saturated,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [r2fft_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [r2fft_pkg::CFG_DATA_W-1:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_D,
        S_RD_I,
        S_MUL,
        S_WR_D,
        S_WR_I,
        S_TW_FIN
    } state_t;

    // round by 2^30 or 2^31, saturate to a sample; msb flags saturation
    function automatic logic [r2fft_pkg::SAMPLE_WIDTH:0] bf_round(
        input logic signed [r2fft_pkg::BF_W-1:0] v,
        input logic                              scale
    );
        logic signed [r2fft_pkg::BF_W-1:0] r;
        logic signed [r2fft_pkg::BF_W-1:0] hi;
        logic signed [r2fft_pkg::BF_W-1:0] lo;
        hi = signed'(r2fft_pkg::BF_W'((1 << (r2fft_pkg::SAMPLE_WIDTH - 1)) - 1));
        lo = -hi - signed'(r2fft_pkg::BF_W'(1));
        if (scale)
            r = (v + (signed'(r2fft_pkg::BF_W'(1)) <<< r2fft_pkg::Q_FRAC))
                >>> (r2fft_pkg::Q_FRAC + 1);
        else
            r = (v + (signed'(r2fft_pkg::BF_W'(1)) <<< (r2fft_pkg::Q_FRAC - 1)))
                >>> r2fft_pkg::Q_FRAC;
        if (r > hi)
            return {1'b1, hi[r2fft_pkg::SAMPLE_WIDTH-1:0]};
        else if (r < lo)
            return {1'b1, lo[r2fft_pkg::SAMPLE_WIDTH-1:0]};
        else
            return {1'b0, r[r2fft_pkg::SAMPLE_WIDTH-1:0]};
    endfunction

    // round a Q.60 sum back to Q1.30 and saturate to 32 bits
    function automatic logic signed [r2fft_pkg::TW_WIDTH-1:0] tw_round(
        input logic signed [r2fft_pkg::ACC_W-1:0] v
    );
        logic signed [r2fft_pkg::ACC_W:0] r;
        logic signed [r2fft_pkg::ACC_W:0] hi;
        logic signed [r2fft_pkg::ACC_W:0] lo;
        hi = signed'((r2fft_pkg::ACC_W + 1)'(64'h0000_0000_7FFF_FFFF));
        lo = -hi - signed'((r2fft_pkg::ACC_W + 1)'(1));
        r  = (signed'((r2fft_pkg::ACC_W + 1)'(v))
              + (signed'((r2fft_pkg::ACC_W + 1)'(1)) <<< (r2fft_pkg::Q_FRAC - 1)))
             >>> r2fft_pkg::Q_FRAC;
        if (r > hi)
            return hi[r2fft_pkg::TW_WIDTH-1:0];
        else if (r < lo)
            return lo[r2fft_pkg::TW_WIDTH-1:0];
        else
            return r[r2fft_pkg::TW_WIDTH-1:0];
    endfunction

    state_t state_reg;

    logic [r2fft_pkg::LOG2_W-1:0]  log2_reg;
    logic                          no_scale_reg;
    logic                          inverse_reg;
    logic                          ovf_reg;
    logic                          rd_pend_reg;
    logic                          out_valid_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] bin_re_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] bin_im_reg;
    logic                          sat_reg;

    logic [r2fft_pkg::STAGE_W-1:0] e_reg;
    logic [r2fft_pkg::STAGE_W-1:0] stage_reg;
    logic [r2fft_pkg::CNT_W-1:0]   j_reg;
    logic [r2fft_pkg::CNT_W-1:0]   i_reg;
    logic [r2fft_pkg::MUL_CNT_W-1:0] k_reg;
    logic                          tw_mode_reg;

    logic signed [r2fft_pkg::TW_WIDTH-1:0]     u_re_reg;
    logic signed [r2fft_pkg::TW_WIDTH-1:0]     u_im_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] xd_re_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] xd_im_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] xi_re_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] xi_im_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] up_re_reg;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] up_im_reg;
    logic signed [r2fft_pkg::PROD_W-1:0]       prod_reg;
    logic signed [r2fft_pkg::ACC_W-1:0]        acc_re_reg;
    logic signed [r2fft_pkg::ACC_W-1:0]        acc_im_reg;

    // sample store and twiddle step store
    logic [2*r2fft_pkg::SAMPLE_WIDTH-1:0] mem [2**r2fft_pkg::ADDR_W];
    logic [2*r2fft_pkg::SAMPLE_WIDTH-1:0] rd_data_reg;
    logic signed [r2fft_pkg::TW_WIDTH-1:0] tw_re_mem [r2fft_pkg::MAX_LOG2];
    logic signed [r2fft_pkg::TW_WIDTH-1:0] tw_im_mem [r2fft_pkg::MAX_LOG2];

    logic                                 in_fire;
    logic                                 mem_we;
    logic [r2fft_pkg::ADDR_W-1:0]         mem_wa;
    logic [r2fft_pkg::ADDR_W-1:0]         mem_ra;
    logic [2*r2fft_pkg::SAMPLE_WIDTH-1:0] mem_wd;

    logic [r2fft_pkg::CNT_W-1:0]   n_w;
    logic [r2fft_pkg::CNT_W-1:0]   span_w;
    logic [r2fft_pkg::CNT_W-1:0]   half_w;
    logic [r2fft_pkg::CNT_W-1:0]   d_w;
    logic [r2fft_pkg::CNT_W:0]     i_adv_w;
    logic [r2fft_pkg::CNT_W-1:0]   j_inc_w;
    logic                          more_i;
    logic                          more_j;
    logic [r2fft_pkg::STAGE_W-1:0] eff_log2;
    logic                          scale;
    logic [r2fft_pkg::TW_AW-1:0]   tw_sel;

    logic signed [r2fft_pkg::TW_WIDTH-1:0] a_re;
    logic signed [r2fft_pkg::TW_WIDTH-1:0] a_im;
    logic signed [r2fft_pkg::TW_WIDTH-1:0] b_re;
    logic signed [r2fft_pkg::TW_WIDTH-1:0] b_im;
    logic signed [r2fft_pkg::TW_WIDTH-1:0] mul_a;
    logic signed [r2fft_pkg::TW_WIDTH-1:0] mul_b;
    logic signed [r2fft_pkg::PROD_W-1:0]   mul_p;

    logic signed [r2fft_pkg::BF_W-1:0]  base_re;
    logic signed [r2fft_pkg::BF_W-1:0]  base_im;
    logic [r2fft_pkg::SAMPLE_WIDTH:0]   r_up_re;
    logic [r2fft_pkg::SAMPLE_WIDTH:0]   r_up_im;
    logic [r2fft_pkg::SAMPLE_WIDTH:0]   r_lo_re;
    logic [r2fft_pkg::SAMPLE_WIDTH:0]   r_lo_im;

    // handshakes
    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || rd_pend_reg || (out_valid_reg && out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign bin_re    = bin_re_reg;
    assign bin_im    = bin_im_reg;
    assign saturated = sat_reg;

    // loop bounds of the current stage
    assign n_w     = r2fft_pkg::CNT_W'(1) << e_reg;
    assign span_w  = r2fft_pkg::CNT_W'(1) << stage_reg;
    assign half_w  = span_w >> 1;
    assign d_w     = i_reg + half_w;
    assign i_adv_w = {1'b0, i_reg} + {1'b0, span_w};
    assign more_i  = i_adv_w < {1'b0, n_w};
    assign j_inc_w = j_reg + r2fft_pkg::CNT_W'(1);
    assign more_j  = j_inc_w < half_w;
    assign eff_log2 = (log2_reg > r2fft_pkg::LOG2_W'(r2fft_pkg::MAX_LOG2))
                      ? r2fft_pkg::STAGE_W'(r2fft_pkg::MAX_LOG2)
                      : r2fft_pkg::STAGE_W'(log2_reg);
    assign scale  = !(no_scale_reg || inverse_reg);
    assign tw_sel = r2fft_pkg::TW_AW'(stage_reg - r2fft_pkg::STAGE_W'(1));

    // complex multiplier operands: sample times U, or U times the stage step
    always_comb
    begin
        if (tw_mode_reg)
        begin
            a_re = u_re_reg;
            a_im = u_im_reg;
            b_re = tw_re_mem[tw_sel];
            b_im = tw_im_mem[tw_sel];
        end
        else
        begin
            a_re = r2fft_pkg::TW_WIDTH'(xd_re_reg);
            a_im = r2fft_pkg::TW_WIDTH'(xd_im_reg);
            b_re = u_re_reg;
            b_im = u_im_reg;
        end
        mul_a = (k_reg == 3'd0 || k_reg == 3'd2) ? a_re : a_im;
        mul_b = (k_reg == 3'd0 || k_reg == 3'd3) ? b_re : b_im;
    end

    assign mul_p = mul_a * mul_b;

    // butterfly outputs from the registered product
    assign base_re = r2fft_pkg::BF_W'(xi_re_reg) <<< r2fft_pkg::Q_FRAC;
    assign base_im = r2fft_pkg::BF_W'(xi_im_reg) <<< r2fft_pkg::Q_FRAC;
    assign r_up_re = bf_round(base_re + r2fft_pkg::BF_W'(acc_re_reg), scale);
    assign r_up_im = bf_round(base_im + r2fft_pkg::BF_W'(acc_im_reg), scale);
    assign r_lo_re = bf_round(base_re - r2fft_pkg::BF_W'(acc_re_reg), scale);
    assign r_lo_im = bf_round(base_im - r2fft_pkg::BF_W'(acc_im_reg), scale);

    // memory port select
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = index[r2fft_pkg::ADDR_W-1:0];
        mem_ra = index[r2fft_pkg::ADDR_W-1:0];
        mem_wd = {sample_re, sample_im};
        case (state_reg)
            S_IDLE:
            begin
                mem_we = in_fire && (kind == r2fft_pkg::KIND_LOAD_SAMPLE);
            end
            S_RD_D:
            begin
                mem_ra = d_w[r2fft_pkg::ADDR_W-1:0];
            end
            S_RD_I:
            begin
                mem_ra = i_reg[r2fft_pkg::ADDR_W-1:0];
            end
            S_WR_D:
            begin
                mem_we = 1'b1;
                mem_wa = d_w[r2fft_pkg::ADDR_W-1:0];
                mem_wd = {r_lo_re[r2fft_pkg::SAMPLE_WIDTH-1:0],
                          r_lo_im[r2fft_pkg::SAMPLE_WIDTH-1:0]};
            end
            S_WR_I:
            begin
                mem_we = 1'b1;
                mem_wa = i_reg[r2fft_pkg::ADDR_W-1:0];
                mem_wd = {up_re_reg, up_im_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sample store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // twiddle step store; stages beyond the store are dropped
    always_ff @(posedge clk)
    begin
        if (in_fire && (kind == r2fft_pkg::KIND_LOAD_TW)
            && (index < r2fft_pkg::INDEX_W'(r2fft_pkg::MAX_LOG2)))
        begin
            tw_re_mem[index[r2fft_pkg::TW_AW-1:0]] <= twiddle_re;
            tw_im_mem[index[r2fft_pkg::TW_AW-1:0]] <= twiddle_im;
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            log2_reg      <= r2fft_pkg::LOG2_RESET;
            no_scale_reg  <= 1'b0;
            inverse_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            bin_re_reg    <= '0;
            bin_im_reg    <= '0;
            sat_reg       <= 1'b0;
            e_reg         <= '0;
            stage_reg     <= '0;
            j_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            tw_mode_reg   <= 1'b0;
            u_re_reg      <= '0;
            u_im_reg      <= '0;
            xd_re_reg     <= '0;
            xd_im_reg     <= '0;
            xi_re_reg     <= '0;
            xi_im_reg     <= '0;
            up_re_reg     <= '0;
            up_im_reg     <= '0;
            prod_reg      <= '0;
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
        end
        else
        begin
            // register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    r2fft_pkg::CFG_LOG2_POINTS:  log2_reg     <= cfg_data;
                    r2fft_pkg::CFG_NO_SCALING:   no_scale_reg <= cfg_data[0];
                    r2fft_pkg::CFG_INVERSE_MODE: inverse_reg  <= cfg_data[0];
                    default: ;
                endcase
            end

            // load the output register in the cycle after a read transfer
            rd_pend_reg <= in_fire && (kind == r2fft_pkg::KIND_READ);
            if (rd_pend_reg)
            begin
                out_valid_reg <= 1'b1;
                bin_re_reg    <= rd_data_reg[2*r2fft_pkg::SAMPLE_WIDTH-1:r2fft_pkg::SAMPLE_WIDTH];
                bin_im_reg    <= rd_data_reg[r2fft_pkg::SAMPLE_WIDTH-1:0];
                sat_reg       <= ovf_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (kind == r2fft_pkg::KIND_RUN))
                    begin
                        ovf_reg <= 1'b0;
                        if (eff_log2 != '0)
                        begin
                            e_reg       <= eff_log2;
                            stage_reg   <= r2fft_pkg::STAGE_W'(1);
                            j_reg       <= '0;
                            i_reg       <= '0;
                            u_re_reg    <= r2fft_pkg::TW_ONE;
                            u_im_reg    <= '0;
                            tw_mode_reg <= 1'b0;
                            state_reg   <= S_RD_D;
                        end
                    end
                end
                S_RD_D:
                begin
                    state_reg <= S_RD_I;
                end
                S_RD_I:
                begin
                    xd_re_reg <= rd_data_reg[2*r2fft_pkg::SAMPLE_WIDTH-1:r2fft_pkg::SAMPLE_WIDTH];
                    xd_im_reg <= rd_data_reg[r2fft_pkg::SAMPLE_WIDTH-1:0];
                    k_reg     <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // capture the upper input as its read lands
                    if (k_reg == '0 && !tw_mode_reg)
                    begin
                        xi_re_reg <= rd_data_reg[2*r2fft_pkg::SAMPLE_WIDTH-1:r2fft_pkg::SAMPLE_WIDTH];
                        xi_im_reg <= rd_data_reg[r2fft_pkg::SAMPLE_WIDTH-1:0];
                    end
                    if (k_reg < r2fft_pkg::MUL_CNT_W'(r2fft_pkg::MUL_STEPS))
                        prod_reg <= mul_p;
                    // accumulate the previous product
                    case (k_reg)
                        3'd1: acc_re_reg <= r2fft_pkg::ACC_W'(prod_reg);
                        3'd2: acc_re_reg <= acc_re_reg - r2fft_pkg::ACC_W'(prod_reg);
                        3'd3: acc_im_reg <= r2fft_pkg::ACC_W'(prod_reg);
                        3'd4: acc_im_reg <= acc_im_reg + r2fft_pkg::ACC_W'(prod_reg);
                        default: ;
                    endcase
                    if (k_reg == r2fft_pkg::MUL_CNT_W'(r2fft_pkg::MUL_STEPS))
                        state_reg <= tw_mode_reg ? S_TW_FIN : S_WR_D;
                    else
                        k_reg <= k_reg + r2fft_pkg::MUL_CNT_W'(1);
                end
                S_WR_D:
                begin
                    up_re_reg <= r_up_re[r2fft_pkg::SAMPLE_WIDTH-1:0];
                    up_im_reg <= r_up_im[r2fft_pkg::SAMPLE_WIDTH-1:0];
                    ovf_reg   <= ovf_reg
                                 | r_up_re[r2fft_pkg::SAMPLE_WIDTH]
                                 | r_up_im[r2fft_pkg::SAMPLE_WIDTH]
                                 | r_lo_re[r2fft_pkg::SAMPLE_WIDTH]
                                 | r_lo_im[r2fft_pkg::SAMPLE_WIDTH];
                    state_reg <= S_WR_I;
                end
                S_WR_I:
                begin
                    // advance butterfly, group, then stage
                    if (more_i)
                    begin
                        i_reg     <= i_adv_w[r2fft_pkg::CNT_W-1:0];
                        state_reg <= S_RD_D;
                    end
                    else if (more_j)
                    begin
                        tw_mode_reg <= 1'b1;
                        k_reg       <= '0;
                        state_reg   <= S_MUL;
                    end
                    else if (stage_reg == e_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        stage_reg <= stage_reg + r2fft_pkg::STAGE_W'(1);
                        j_reg     <= '0;
                        i_reg     <= '0;
                        u_re_reg  <= r2fft_pkg::TW_ONE;
                        u_im_reg  <= '0;
                        state_reg <= S_RD_D;
                    end
                end
                S_TW_FIN:
                begin
                    u_re_reg    <= tw_round(acc_re_reg);
                    u_im_reg    <= tw_round(acc_im_reg);
                    j_reg       <= j_inc_w;
                    i_reg       <= j_inc_w;
                    tw_mode_reg <= 1'b0;
                    state_reg   <= S_RD_D;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a bin appears only after a read transfer
    a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(rd_pend_reg)
            && $past(in_valid && !in_stall && kind == r2fft_pkg::KIND_READ, 2))
        else $error("bin presented without a read transfer");

    // butterfly addresses stay inside the transform
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg < n_w) && (d_w < n_w))
        else $error("butterfly address beyond transform size");

    // group counter stays below half the span
    a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (j_reg < half_w))
        else $error("twiddle group beyond half span");

    // saturation flag rises only on a butterfly write
    a_ovf_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(state_reg == S_WR_D))
        else $error("saturation flag set outside a butterfly");

endmodule

// ----- tb/radix2_dit_fft_inplace_tb.sv -----
// Self-checking testbench for the in-place radix-2 DIT FFT block.
// Depends on r2fft_pkg and radix2_dit_fft_inplace; predicts every read bin.
module radix2_dit_fft_inplace_tb;

    localparam int NPTS       = 1 << r2fft_pkg::MAX_LOG2;
    localparam int IDLE_LIMIT = 400000;
    localparam int ITEM_GOAL  = 900;

    typedef struct {
        shortint re;
        shortint im;
        bit      sat;
    } bin_t;

    // predictor of the transform plus the queue of pending bins
    class fft_scoreboard;
        shortint st_re[NPTS];
        shortint st_im[NPTS];
        int      tw_re[r2fft_pkg::MAX_LOG2];
        int      tw_im[r2fft_pkg::MAX_LOG2];
        bit      overflow;
        int      log2_pts;
        bit      no_scale;
        bit      inverse;
        bin_t    pending_bins[$];
        int      errors;

        function new();
            log2_pts = 10;
            no_scale = 0;
            inverse  = 0;
            overflow = 0;
            errors   = 0;
        endfunction

        function void configure(logic [r2fft_pkg::CFG_INDEX_W-1:0] idx,
                                logic [r2fft_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                r2fft_pkg::CFG_LOG2_POINTS:  log2_pts = data;
                r2fft_pkg::CFG_NO_SCALING:   no_scale = data[0];
                r2fft_pkg::CFG_INVERSE_MODE: inverse  = data[0];
                default: ;
            endcase
        endfunction

        function shortint clip(longint v);
            if (v > 32767) begin
                overflow = 1;
                return 16'sh7fff;
            end
            if (v < -32768) begin
                overflow = 1;
                return -16'sh8000;
            end
            return shortint'(v);
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        // rounded Q30 sum of two products without forming the full sum
        function int q30_sum(longint p1, longint p2);
            longint hi;
            longint lb;
            longint r;
            hi = (p1 >>> 1) + (p2 >>> 1);
            lb = (p1 & 64'sd1) + (p2 & 64'sd1);
            r  = (hi + (longint'(1) <<< 28) + (lb >>> 1)) >>> 29;
            if (r > 64'sd2147483647) return 32'sh7fffffff;
            if (r < -64'sd2147483648) return 32'sh80000000;
            return int'(r);
        endfunction

        function void run_transform();
            int     e;
            int     n;
            int     sh;
            int     span;
            int     half;
            int     d;
            longint ur, ui, wr, wi, xr, xi, pr, pi, br, bi;
            int     nr, ni;
            e  = (log2_pts > r2fft_pkg::MAX_LOG2) ? r2fft_pkg::MAX_LOG2 : log2_pts;
            n  = 1 << e;
            sh = (no_scale || inverse) ? 30 : 31;
            overflow = 0;
            for (int stage = 1; stage <= e; stage++) begin
                span = 1 << stage;
                half = span >> 1;
                ur = longint'(1) <<< 30;
                ui = 0;
                wr = tw_re[stage-1];
                wi = tw_im[stage-1];
                for (int j = 0; j < half; j++) begin
                    for (int i = j; i < n; i += span) begin
                        d  = i + half;
                        xr = st_re[d];
                        xi = st_im[d];
                        pr = xr * ur - xi * ui;
                        pi = xi * ur + xr * ui;
                        br = longint'(st_re[i]) <<< 30;
                        bi = longint'(st_im[i]) <<< 30;
                        st_re[d] = clip(round_shift(br - pr, sh));
                        st_im[d] = clip(round_shift(bi - pi, sh));
                        st_re[i] = clip(round_shift(br + pr, sh));
                        st_im[i] = clip(round_shift(bi + pi, sh));
                    end
                    nr = q30_sum(ur * wr, -(ui * wi));
                    ni = q30_sum(ur * wi, ui * wr);
                    ur = nr;
                    ui = ni;
                end
            end
        endfunction

        // note one accepted command and queue the bin a read returns
        function void note(r2fft_pkg::kind_t k, int idx, shortint sr, shortint si,
                           int tr, int ti);
            bin_t b;
            case (k)
                r2fft_pkg::KIND_LOAD_TW:
                    if (idx < r2fft_pkg::MAX_LOG2) begin
                        tw_re[idx] = tr;
                        tw_im[idx] = ti;
                    end
                r2fft_pkg::KIND_LOAD_SAMPLE: begin
                    st_re[idx % NPTS] = sr;
                    st_im[idx % NPTS] = si;
                end
                r2fft_pkg::KIND_RUN: run_transform();
                default: begin
                    b.re  = st_re[idx % NPTS];
                    b.im  = st_im[idx % NPTS];
                    b.sat = overflow;
                    pending_bins.push_back(b);
                end
            endcase
        endfunction

        function void check(shortint re, shortint im, bit sat);
            bin_t b;
            if (pending_bins.size() == 0) begin
                $error("unexpected bin: bin_re %0d bin_im %0d", re, im);
                errors++;
                return;
            end
            b = pending_bins.pop_front();
            if (b.re != re) begin
                $error("bin_re expected %0d actual %0d", b.re, re);
                errors++;
            end
            if (b.im != im) begin
                $error("bin_im expected %0d actual %0d", b.im, im);
                errors++;
            end
            if (b.sat != sat) begin
                $error("saturated expected %0d actual %0d", b.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                                      clk;
    logic                                      rst_n;
    logic                                      in_valid;
    logic                                      in_stall;
    logic [1:0]                                kind;
    logic [r2fft_pkg::INDEX_W-1:0]             index;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] sample_re;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] sample_im;
    logic signed [r2fft_pkg::TW_WIDTH-1:0]     twiddle_re;
    logic signed [r2fft_pkg::TW_WIDTH-1:0]     twiddle_im;
    logic                                      out_valid;
    logic                                      out_stall;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] bin_re;
    logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] bin_im;
    logic                                      saturated;
    logic                                      cfg_valid;
    logic                                      cfg_ready;
    logic [r2fft_pkg::CFG_INDEX_W-1:0]         cfg_index;
    logic [r2fft_pkg::CFG_DATA_W-1:0]          cfg_data;

    fft_scoreboard sb = new();
    bit            written[NPTS];
    bit            tw_written[r2fft_pkg::MAX_LOG2];
    int            item_count = 0;
    bit            quiet = 0;
    bit            hold_req = 0;
    int            idle_cycles = 0;

    radix2_dit_fft_inplace dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .index      (index),
        .sample_re  (sample_re),
        .sample_im  (sample_im),
        .twiddle_re (twiddle_re),
        .twiddle_im (twiddle_im),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_re     (bin_re),
        .bin_im     (bin_im),
        .saturated  (saturated),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // check each bin transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(bin_re, bin_im, saturated);
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_req = 0;
                out_stall <= 0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 0;
            end
            else
                out_stall <= 0;
        end
    end

    // watchdog: end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("radix2_dit_fft_inplace_tb: errors");
            $finish;
        end
    end

    function automatic shortint rand_sample();
        if ($urandom_range(0, 1)) return shortint'($urandom);
        return shortint'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    function automatic int rand_twiddle();
        if ($urandom_range(0, 1)) return int'($urandom);
        return int'($urandom_range(0, 32'h7fffffff)) - 32'h40000000;
    endfunction

    // offer one command and hold it until transfer, then maybe idle
    task automatic send(r2fft_pkg::kind_t k, int idx, shortint sr = 0, shortint si = 0,
                        int tr = 0, int ti = 0);
        in_valid   <= 1;
        kind       <= k;
        index      <= r2fft_pkg::INDEX_W'(idx);
        sample_re  <= sr;
        sample_im  <= si;
        twiddle_re <= tr;
        twiddle_im <= ti;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note(k, idx, sr, si, tr, ti);
        if (k == r2fft_pkg::KIND_LOAD_SAMPLE) written[idx] = 1;
        if (k == r2fft_pkg::KIND_LOAD_TW && idx < r2fft_pkg::MAX_LOG2) tw_written[idx] = 1;
        if (!(k == r2fft_pkg::KIND_LOAD_TW && idx >= r2fft_pkg::MAX_LOG2)) item_count++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // stop offering and wait until every bin has come back
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending_bins.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [r2fft_pkg::CFG_INDEX_W-1:0] idx,
                             logic [r2fft_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.configure(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // read a written address, preferring a random one
    task automatic read_written(int n);
        int a;
        a = $urandom_range(0, NPTS - 1);
        if (!written[a]) a = $urandom_range(0, n - 1);
        send(r2fft_pkg::KIND_READ, a);
    endtask

    // one transform: twiddles, samples, run, reads; some noise in between
    task automatic transform_phase();
        int e;
        int n;
        int nreads;
        e = (sb.log2_pts > r2fft_pkg::MAX_LOG2) ? r2fft_pkg::MAX_LOG2 : sb.log2_pts;
        n = 1 << e;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 2))
                    0: send(r2fft_pkg::KIND_LOAD_SAMPLE, $urandom_range(0, NPTS - 1),
                            rand_sample(), rand_sample());
                    1: send(r2fft_pkg::KIND_LOAD_TW, $urandom_range(0, NPTS - 1), 0, 0,
                            rand_twiddle(), rand_twiddle());
                    default: read_written(1);
                endcase
            end
        for (int s = 0; s < r2fft_pkg::MAX_LOG2; s++)
            send(r2fft_pkg::KIND_LOAD_TW, s, 0, 0, rand_twiddle(), rand_twiddle());
        for (int a = 0; a < n; a++)
        begin
            send(r2fft_pkg::KIND_LOAD_SAMPLE, a, rand_sample(), rand_sample());
            if ($urandom_range(0, 15) == 0)
                send(r2fft_pkg::KIND_LOAD_SAMPLE, $urandom_range(0, NPTS - 1),
                     rand_sample(), rand_sample());
        end
        send(r2fft_pkg::KIND_RUN, $urandom_range(0, NPTS - 1));
        if ($urandom_range(0, 5) == 0)
            send(r2fft_pkg::KIND_RUN, 0);
        nreads = (n < 12) ? n : 12;
        for (int a = 0; a < nreads; a++)
            send(r2fft_pkg::KIND_READ, a);
        repeat ($urandom_range(1, 4)) read_written(n);
        drain();
    endtask

    task automatic set_mode(int lg, bit ns, bit inv);
        write_cfg(r2fft_pkg::CFG_LOG2_POINTS, r2fft_pkg::CFG_DATA_W'(lg));
        write_cfg(r2fft_pkg::CFG_NO_SCALING, {3'($urandom_range(0, 7)), ns});
        write_cfg(r2fft_pkg::CFG_INVERSE_MODE, {3'($urandom_range(0, 7)), inv});
    endtask

    initial
    begin
        int phase;
        rst_n      = 0;
        in_valid   = 0;
        kind       = r2fft_pkg::KIND_LOAD_TW;
        index      = 0;
        sample_re  = 0;
        sample_im  = 0;
        twiddle_re = 0;
        twiddle_im = 0;
        cfg_valid  = 0;
        cfg_index  = r2fft_pkg::CFG_LOG2_POINTS;
        cfg_data   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: four points, extreme values, ignored twiddle stages
        set_mode(2, 0, 0);
        send(r2fft_pkg::KIND_LOAD_TW, 0, 0, 0, 32'sh7fffffff, 32'sh80000000);
        send(r2fft_pkg::KIND_LOAD_TW, 1, 0, 0, r2fft_pkg::TW_ONE, 0);
        send(r2fft_pkg::KIND_LOAD_TW, r2fft_pkg::MAX_LOG2, 0, 0, 32'sh80000000, 32'sh7fffffff);
        send(r2fft_pkg::KIND_LOAD_TW, NPTS - 1, 0, 0, -1, -1);
        send(r2fft_pkg::KIND_LOAD_SAMPLE, 0, 16'sh7fff, -16'sh8000);
        send(r2fft_pkg::KIND_LOAD_SAMPLE, 1, -16'sh8000, 16'sh7fff);
        send(r2fft_pkg::KIND_LOAD_SAMPLE, 2, 0, 0);
        send(r2fft_pkg::KIND_LOAD_SAMPLE, 3, -1, 1);
        send(r2fft_pkg::KIND_LOAD_SAMPLE, NPTS - 1, -1, -1);
        send(r2fft_pkg::KIND_READ, NPTS - 1);
        send(r2fft_pkg::KIND_RUN, 0);
        for (int a = 0; a < 4; a++)
            send(r2fft_pkg::KIND_READ, a);
        send(r2fft_pkg::KIND_READ, NPTS - 1);
        drain();
        set_mode(2, 1, 0);
        send(r2fft_pkg::KIND_RUN, 0);
        send(r2fft_pkg::KIND_READ, 0);
        send(r2fft_pkg::KIND_READ, 1);
        drain();

        // random phases; the first few cover the register extremes, and a
        // single full-size run covers the size clamp
        phase = 0;
        while (item_count < ITEM_GOAL || phase < 8)
        begin
            case (phase)
                0: set_mode(0, 0, 0);
                1: set_mode(1, 1, 0);
                2: set_mode(15, 0, 0);
                3: set_mode(5, 1, 1);
                4: set_mode(3, 0, 1);
                5: set_mode(4, 1, 0);
                default: set_mode($urandom_range(0, 5), $urandom_range(0, 1),
                                  $urandom_range(0, 1));
            endcase
            if (phase == 6)
            begin
                // hold the output so the block fills and stalls its input
                hold_req = 1;
                for (int a = 0; a < 20; a++)
                    read_written(1);
            end
            if (item_count > ITEM_GOAL - 150)
                quiet = 1;
            transform_phase();
            phase++;
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.pending_bins.size() != 0)
        begin
            $error("%0d bins never returned", sb.pending_bins.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("radix2_dit_fft_inplace_tb: clean");
        else
            $display("radix2_dit_fft_inplace_tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/r2fft_pkg.sv
hdl/radix2_dit_fft_inplace.sv
tb/radix2_dit_fft_inplace_tb.sv
